// File: sv/planar_pixel_interpolator_core_macros.svh
// Assertion macros for the planar pixel interpolator.
`ifndef PLANAR_PIXEL_INTERPOLATOR_CORE_MACROS_SVH
`define PLANAR_PIXEL_INTERPOLATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication under reset.
`define PPI_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");

// Next-cycle implication under reset.
`define PPI_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");

`else

`define PPI_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define PPI_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// File: sv/ppi_pkg.sv
package ppi_pkg;

  // Fixed-point position format
  localparam int POS_W     = 18;
  localparam int FRAC_BITS = 8;
  localparam int HALF_UNIT = 1 << (FRAC_BITS - 1);
  localparam int NX_W      = POS_W - FRAC_BITS + 1;

  // Image geometry and store layout
  localparam int IMG_WIDTH = 256;
  localparam int X_W       = $clog2(IMG_WIDTH);
  localparam int COORD_W   = X_W;
  localparam int ADDR_W    = 16;
  localparam int NUM_BANKS = 4;
  localparam int BANK_SEL_W = 2;
  localparam int BANK_AW   = ADDR_W - BANK_SEL_W;

  // Pixel word
  localparam int PIX_W  = 24;
  localparam int CHAN_W = 8;
  localparam int N_CHAN = PIX_W / CHAN_W;

  // Product and sum widths of the plane evaluation
  localparam int IPROD_W = PIX_W + FRAC_BITS + 2;
  localparam int ISUM_W  = IPROD_W + 1;
  localparam int CPROD_W = CHAN_W + FRAC_BITS + 2;
  localparam int CSUM_W  = CPROD_W + 1;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 8;

  typedef enum logic [CFG_AW-1:0] {
    CFG_INDEX_MODE   = 3'd0,
    CFG_BOUND_LOW_X  = 3'd1,
    CFG_BOUND_HIGH_X = 3'd2,
    CFG_BOUND_LOW_Y  = 3'd3,
    CFG_BOUND_HIGH_Y = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef struct packed {
    logic               index_mode;
    logic [COORD_W-1:0] bound_low_x;
    logic [COORD_W-1:0] bound_high_x;
    logic [COORD_W-1:0] bound_low_y;
    logic [COORD_W-1:0] bound_high_y;
  } cfg_t;

  typedef struct packed {
    logic                    action;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [ADDR_W-1:0]       write_addr;
    logic [PIX_W-1:0]        write_pixel;
  } in_word_t;

  // One axis after rounding: nearest pixel, fraction magnitude and side
  typedef struct packed {
    logic signed [NX_W-1:0] nx;
    logic [FRAC_BITS-1:0]   mag;
    logic                   pos;
    logic                   nz;
  } axis_t;

  typedef struct packed {
    logic              valid;
    logic              is_query;
    axis_t             ax_x;
    axis_t             ax_y;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wpixel;
  } front_t;

  typedef struct packed {
    logic                 valid;
    logic                 in_win;
    logic                 use_plane;
    logic [FRAC_BITS-1:0] ax;
    logic [FRAC_BITS-1:0] ay;
    logic [PIX_W-1:0]     z0;
    logic [PIX_W-1:0]     z1;
    logic [PIX_W-1:0]     z2;
  } plane_in_t;

  typedef struct packed {
    logic             valid;
    logic             in_win;
    logic [PIX_W-1:0] pixel;
  } res_t;

endpackage

// File: sv/ppi_if.sv
// Query and write words into the block
interface ppi_in_if import ppi_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [ADDR_W-1:0]       write_addr;
  logic [PIX_W-1:0]        write_pixel;

  modport source (output valid, action, pos_x, pos_y, write_addr, write_pixel,
                  input ready);
  modport sink (input valid, action, pos_x, pos_y, write_addr, write_pixel,
                output ready);
endinterface

// Result words out of the block
interface ppi_out_if import ppi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             inside_res;
  logic [PIX_W-1:0] pixel_out;

  modport source (output valid, inside_res, pixel_out, input ready);
  modport sink (input valid, inside_res, pixel_out, output ready);
endinterface

// Register writes
interface ppi_cfg_if import ppi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] addr;
  logic [CFG_DW-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// File: sv/ppi_bank_ram.sv
module ppi_bank_ram #(
  parameter int ADDR_W = 14,
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/ppi_round.sv
module ppi_round import ppi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  logic     in_valid,
  input  in_word_t in_w,
  output front_t   s1
);

  front_t s1_r, s1_nxt;

  // Round half away from zero: bias by half, or half minus one when negative
  function automatic axis_t round_axis(input logic signed [POS_W-1:0] p);
    logic [FRAC_BITS:0]     c_e;
    logic [FRAC_BITS:0]     r_e;
    logic signed [POS_W:0]  s;
    axis_t                  a;
    c_e = p[POS_W-1] ? (FRAC_BITS+1)'(HALF_UNIT - 1) : (FRAC_BITS+1)'(HALF_UNIT);
    s = $signed({p[POS_W-1], p}) + $signed({{(POS_W-FRAC_BITS){1'b0}}, c_e});
    a.nx = s[POS_W:FRAC_BITS];
    r_e = {1'b0, s[FRAC_BITS-1:0]};
    if (r_e >= c_e) begin
      a.pos = 1'b1;
      a.mag = FRAC_BITS'(r_e - c_e);
    end else begin
      a.pos = 1'b0;
      a.mag = FRAC_BITS'(c_e - r_e);
    end
    a.nz = (r_e != c_e);
    return a;
  endfunction

  // Build the first stage word
  always_comb begin
    s1_nxt.valid    = in_valid;
    s1_nxt.is_query = (in_w.action == ACT_QUERY);
    s1_nxt.ax_x     = round_axis(in_w.pos_x);
    s1_nxt.ax_y     = round_axis(in_w.pos_y);
    s1_nxt.waddr    = in_w.write_addr;
    s1_nxt.wpixel   = in_w.write_pixel;
  end

  // Advance with the pipeline, hold on stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1 = s1_r;

endmodule

// File: sv/ppi_store.sv
module ppi_store import ppi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  cfg_t      cfg,
  input  front_t    s1,
  output plane_in_t s2
);

  typedef struct packed {
    logic                 valid;
    logic                 in_win;
    logic                 use_plane;
    logic [FRAC_BITS-1:0] ax;
    logic [FRAC_BITS-1:0] ay;
    logic                 cx0;
    logic                 cy0;
  } sel_t;

  sel_t s2_r, s2_nxt;

  logic                  win_x, win_y, nb_x_ok, nb_y_ok;
  logic [COORD_W-1:0]    cx, cy, x1, y2;
  logic [BANK_AW-1:0]    idx0, idx1, idx2, widx;
  logic [BANK_SEL_W-1:0] wbank;
  logic [BANK_AW-1:0]    raddr [NUM_BANKS];
  logic                  we    [NUM_BANKS];
  logic [PIX_W-1:0]      rdata [NUM_BANKS];

  function automatic logic in_range(input logic signed [NX_W-1:0] v,
                                    input logic [COORD_W-1:0] lo,
                                    input logic [COORD_W-1:0] hi);
    logic signed [NX_W-1:0] lo_s;
    logic signed [NX_W-1:0] hi_s;
    lo_s = $signed({{(NX_W-COORD_W){1'b0}}, lo});
    hi_s = $signed({{(NX_W-COORD_W){1'b0}}, hi});
    return v inside {[lo_s:hi_s]};
  endfunction

  // Window checks and neighbor coordinates
  always_comb begin
    win_x = in_range(s1.ax_x.nx, cfg.bound_low_x, cfg.bound_high_x);
    win_y = in_range(s1.ax_y.nx, cfg.bound_low_y, cfg.bound_high_y);
    cx = s1.ax_x.nx[COORD_W-1:0];
    cy = s1.ax_y.nx[COORD_W-1:0];
    // neighbor on the fraction's side stays in the window
    nb_x_ok = s1.ax_x.pos ? (cx < cfg.bound_high_x) : (cx > cfg.bound_low_x);
    nb_y_ok = s1.ax_y.pos ? (cy < cfg.bound_high_y) : (cy > cfg.bound_low_y);
    x1 = s1.ax_x.pos ? cx + COORD_W'(1) : cx - COORD_W'(1);
    y2 = s1.ax_y.pos ? cy + COORD_W'(1) : cy - COORD_W'(1);
    idx0 = {cy[COORD_W-1:1], cx[COORD_W-1:1]};
    idx1 = {cy[COORD_W-1:1], x1[COORD_W-1:1]};
    idx2 = {y2[COORD_W-1:1], cx[COORD_W-1:1]};
    wbank = {s1.waddr[X_W], s1.waddr[0]};
    widx  = {s1.waddr[ADDR_W-1:X_W+1], s1.waddr[X_W-1:1]};
  end

  // Steer each bank: banks split by row and column parity
  always_comb begin
    logic [BANK_SEL_W-1:0] bsel;
    logic                  row_same;
    logic                  col_same;
    bsel = '0;
    row_same = 1'b0;
    col_same = 1'b0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      bsel = BANK_SEL_W'(b);
      row_same = (bsel[1] == cy[0]);
      col_same = (bsel[0] == cx[0]);
      if (row_same && !col_same) begin
        raddr[b] = idx1;
      end else if (!row_same && col_same) begin
        raddr[b] = idx2;
      end else begin
        raddr[b] = idx0;
      end
      we[b] = adv && s1.valid && !s1.is_query && (bsel == wbank);
    end
  end

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    ppi_bank_ram #(
      .ADDR_W (BANK_AW),
      .DATA_W (PIX_W)
    ) u_ram (
      .clk   (clk),
      .we    (we[g]),
      .waddr (widx),
      .wdata (s1.wpixel),
      .re    (adv),
      .raddr (raddr[g]),
      .rdata (rdata[g])
    );
  end

  // Select word for the read stage; writes drop out here
  always_comb begin
    s2_nxt.valid     = s1.valid && s1.is_query;
    s2_nxt.in_win    = win_x && win_y;
    s2_nxt.use_plane = (s1.ax_x.nz || s1.ax_y.nz) && nb_x_ok && nb_y_ok;
    s2_nxt.ax        = s1.ax_x.mag;
    s2_nxt.ay        = s1.ax_y.mag;
    s2_nxt.cx0       = cx[0];
    s2_nxt.cy0       = cy[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else if (adv) begin
      s2_r <= s2_nxt;
    end
  end

  // Pick the three pixels out of the bank outputs
  always_comb begin
    s2.valid     = s2_r.valid;
    s2.in_win    = s2_r.in_win;
    s2.use_plane = s2_r.use_plane;
    s2.ax        = s2_r.ax;
    s2.ay        = s2_r.ay;
    s2.z0        = rdata[{s2_r.cy0, s2_r.cx0}];
    s2.z1        = rdata[{s2_r.cy0, ~s2_r.cx0}];
    s2.z2        = rdata[{~s2_r.cy0, s2_r.cx0}];
  end

endmodule

// File: sv/ppi_plane.sv
module ppi_plane import ppi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      index_mode,
  input  plane_in_t s2,
  output res_t      s3
);

  typedef struct packed {
    logic                              valid;
    logic                              in_win;
    logic                              use_plane;
    logic [PIX_W-1:0]                  z0;
    logic [IPROD_W-1:0]                ip1;
    logic [IPROD_W-1:0]                ip2;
    logic [N_CHAN-1:0][CPROD_W-1:0]    cp1;
    logic [N_CHAN-1:0][CPROD_W-1:0]    cp2;
  } prod_t;

  prod_t s3_r, s3_nxt;

  // Differences times fraction magnitudes, whole word and per channel
  always_comb begin
    logic signed [PIX_W:0]     d1;
    logic signed [PIX_W:0]     d2;
    logic signed [CHAN_W:0]    c1;
    logic signed [CHAN_W:0]    c2;
    logic signed [FRAC_BITS:0] axs;
    logic signed [FRAC_BITS:0] ays;
    logic signed [IPROD_W-1:0] pi1;
    logic signed [IPROD_W-1:0] pi2;
    logic signed [CPROD_W-1:0] pc1;
    logic signed [CPROD_W-1:0] pc2;
    axs = $signed({1'b0, s2.ax});
    ays = $signed({1'b0, s2.ay});
    d1 = $signed({1'b0, s2.z1}) - $signed({1'b0, s2.z0});
    d2 = $signed({1'b0, s2.z2}) - $signed({1'b0, s2.z0});
    pi1 = IPROD_W'(d1) * IPROD_W'(axs);
    pi2 = IPROD_W'(d2) * IPROD_W'(ays);
    s3_nxt.valid     = s2.valid;
    s3_nxt.in_win    = s2.in_win;
    s3_nxt.use_plane = s2.use_plane;
    s3_nxt.z0        = s2.z0;
    s3_nxt.ip1       = pi1;
    s3_nxt.ip2       = pi2;
    c1 = '0;
    c2 = '0;
    pc1 = '0;
    pc2 = '0;
    for (int c = 0; c < N_CHAN; c++) begin
      c1 = $signed({1'b0, s2.z1[c*CHAN_W +: CHAN_W]}) -
           $signed({1'b0, s2.z0[c*CHAN_W +: CHAN_W]});
      c2 = $signed({1'b0, s2.z2[c*CHAN_W +: CHAN_W]}) -
           $signed({1'b0, s2.z0[c*CHAN_W +: CHAN_W]});
      pc1 = CPROD_W'(c1) * CPROD_W'(axs);
      pc2 = CPROD_W'(c2) * CPROD_W'(ays);
      s3_nxt.cp1[c] = pc1;
      s3_nxt.cp2[c] = pc2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.valid <= 1'b0;
    end else if (adv) begin
      s3_r <= s3_nxt;
    end
  end

  // Sum the plane terms, truncate the fraction, pick by mode
  always_comb begin
    logic signed [ISUM_W-1:0] n_idx;
    logic signed [CSUM_W-1:0] n_ch;
    logic [PIX_W-1:0]         idx_pix;
    logic [PIX_W-1:0]         col_pix;
    n_idx = $signed({{(ISUM_W-PIX_W-FRAC_BITS){1'b0}}, s3_r.z0, {FRAC_BITS{1'b0}}}) +
            ISUM_W'($signed(s3_r.ip1)) + ISUM_W'($signed(s3_r.ip2));
    idx_pix = n_idx[ISUM_W-1] ? '0 : n_idx[FRAC_BITS +: PIX_W];
    n_ch = '0;
    col_pix = '0;
    for (int c = 0; c < N_CHAN; c++) begin
      n_ch = $signed({{(CSUM_W-CHAN_W-FRAC_BITS){1'b0}}, s3_r.z0[c*CHAN_W +: CHAN_W],
                      {FRAC_BITS{1'b0}}}) +
             CSUM_W'($signed(s3_r.cp1[c])) + CSUM_W'($signed(s3_r.cp2[c]));
      col_pix[c*CHAN_W +: CHAN_W] = n_ch[CSUM_W-1] ? '0 : n_ch[FRAC_BITS +: CHAN_W];
    end
    s3.valid  = s3_r.valid;
    s3.in_win = s3_r.in_win;
    if (!s3_r.in_win) begin
      s3.pixel = '0;
    end else if (!s3_r.use_plane) begin
      s3.pixel = s3_r.z0;
    end else if (index_mode) begin
      s3.pixel = idx_pix;
    end else begin
      s3.pixel = col_pix;
    end
  end

endmodule

// File: sv/planar_pixel_interpolator_core.sv
// A query's result passes the round, store, plane and output registers; write words give no result.
// Throughput: one word per cycle, in both directions, stalls only on output backpressure.
// The store is split into four banks by row and column parity, so the three pixels of a
// query are read at once, each from its own bank's read port; writes use each bank's write port.
// Reset clears the pipeline valid bits and sets the configuration registers to their reset values;
// the image store is not cleared and holds garbage until written.
`include "planar_pixel_interpolator_core_macros.svh"

module planar_pixel_interpolator_core import ppi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ppi_in_if.sink    in_ch,
  ppi_out_if.source out_ch,
  ppi_cfg_if.sink   cfg_ch
);

  cfg_t      cfg_r, cfg_nxt;
  in_word_t  in_w;
  front_t    s1;
  plane_in_t s2;
  res_t      s3;
  logic      adv;
  logic      out_valid_r;
  logic      out_inside_r;
  logic [PIX_W-1:0] out_pixel_r;

  // Advance the whole pipeline whenever the output register can take a word
  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign cfg_ch.ready = 1'b1;

  // Register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        CFG_INDEX_MODE:   cfg_nxt.index_mode   = cfg_ch.data[0];
        CFG_BOUND_LOW_X:  cfg_nxt.bound_low_x  = cfg_ch.data[COORD_W-1:0];
        CFG_BOUND_HIGH_X: cfg_nxt.bound_high_x = cfg_ch.data[COORD_W-1:0];
        CFG_BOUND_LOW_Y:  cfg_nxt.bound_low_y  = cfg_ch.data[COORD_W-1:0];
        CFG_BOUND_HIGH_Y: cfg_nxt.bound_high_y = cfg_ch.data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.index_mode   <= 1'b0;
      cfg_r.bound_low_x  <= '0;
      cfg_r.bound_high_x <= '1;
      cfg_r.bound_low_y  <= '0;
      cfg_r.bound_high_y <= '1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Pack the input word
  always_comb begin
    in_w.action      = in_ch.action;
    in_w.pos_x       = in_ch.pos_x;
    in_w.pos_y       = in_ch.pos_y;
    in_w.write_addr  = in_ch.write_addr;
    in_w.write_pixel = in_ch.write_pixel;
  end

  ppi_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_ch.valid),
    .in_w     (in_w),
    .s1       (s1)
  );

  ppi_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .cfg   (cfg_r),
    .s1    (s1),
    .s2    (s2)
  );

  ppi_plane u_plane (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .index_mode (cfg_r.index_mode),
    .s2         (s2),
    .s3         (s3)
  );

  // Output register: load on advance, hold while the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_inside_r <= s3.in_win;
      out_pixel_r  <= s3.pixel;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.inside_res = out_inside_r;
  assign out_ch.pixel_out  = out_pixel_r;

  // Outside queries carry a zero pixel
  `PPI_ASSERT_IMPLY(a_outside_zero, clk, rst_n, out_valid_r && !out_inside_r, out_pixel_r == '0)
  // Last stage holds while the output stalls
  `PPI_ASSERT_NEXT(a_stall_hold, clk, rst_n, !adv, $stable(s3.valid))
  // A write word never enters the read stage
  `PPI_ASSERT_NEXT(a_write_drop, clk, rst_n, s1.valid && !s1.is_query && adv, !s2.valid)

endmodule

// File: test/tb.sv
module tb;
  import ppi_pkg::*;

  localparam int     PIX_ONE   = 1 << FRAC_BITS;
  localparam longint CH_MASK   = (1 << CHAN_W) - 1;
  localparam int     N_PHASES  = 10;
  localparam int     PHASE_LEN = 175;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    bit             in_win;
    bit [PIX_W-1:0] pixel;
  } answer_t;

  // Nearest pixel lookup: what a query reads and how it weighs it
  typedef struct {
    bit              in_win;
    bit              use_plane;
    bit [ADDR_W-1:0] a0;
    bit [ADDR_W-1:0] a1;
    bit [ADDR_W-1:0] a2;
    longint          ax;
    longint          ay;
  } lookup_t;

  typedef enum {ROW_WRITE, ROW_QUERY, ROW_REG} row_kind_t;

  // a/b: address and pixel for a write, register and value for a register row
  typedef struct {
    row_kind_t kind;
    int        a;
    int        b;
    int        px;
    int        py;
    bit        typed;
    bit        want_inside;
    int        want_pixel;
  } drow_t;

  logic clk = 1'b0;
  logic rst_n;

  ppi_in_if  in_ch ();
  ppi_out_if out_ch ();
  ppi_cfg_if cfg_ch ();

  planar_pixel_interpolator_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  // Shadow of the block state
  bit [PIX_W-1:0] image_copy [2**ADDR_W];
  bit             written_map [2**ADDR_W];
  bit             idx_mode = 1'b0;
  longint         win_lx = 0;
  longint         win_hx = 255;
  longint         win_ly = 0;
  longint         win_hy = 255;

  answer_t pending_answers [$];
  int      mismatch_count = 0;
  int      send_gap_pct   = 30;
  int      sink_stall_pct = 30;

  // Directed words; expected values typed in only where obvious
  drow_t directed_rows [25] = '{
    '{ROW_WRITE, 'h0000, 'hFF00FF, 0, 0, 0, 0, 0},
    '{ROW_WRITE, 'h0001, 'h00FF00, 0, 0, 0, 0, 0},
    '{ROW_WRITE, 'h0100, 'h0000FF, 0, 0, 0, 0, 0},
    '{ROW_WRITE, 'h0101, 'h123456, 0, 0, 0, 0, 0},
    '{ROW_QUERY, 0, 0, 0, 0, 1, 1, 'hFF00FF},
    '{ROW_QUERY, 0, 0, -1, 0, 1, 1, 'hFF00FF},
    '{ROW_QUERY, 0, 0, -128, 0, 1, 0, 0},
    '{ROW_QUERY, 0, 0, 128, 128, 0, 0, 0},
    '{ROW_QUERY, 0, 0, 64, 64, 0, 0, 0},
    '{ROW_QUERY, 0, 0, 0, 100, 0, 0, 0},
    '{ROW_QUERY, 0, 0, 131071, 0, 1, 0, 0},
    '{ROW_QUERY, 0, 0, -131072, 0, 1, 0, 0},
    '{ROW_QUERY, 0, 0, 0, 131071, 1, 0, 0},
    '{ROW_QUERY, 0, 0, 0, -131072, 1, 0, 0},
    '{ROW_WRITE, 'hFFFF, 'hFFFFFF, 0, 0, 0, 0, 0},
    '{ROW_WRITE, 'hFFFE, 'h000000, 0, 0, 0, 0, 0},
    '{ROW_WRITE, 'hFEFF, 'h000000, 0, 0, 0, 0, 0},
    '{ROW_QUERY, 0, 0, 65407, 65407, 1, 1, 'hFFFFFF},
    '{ROW_QUERY, 0, 0, 65153, 65153, 0, 0, 0},
    '{ROW_REG, CFG_INDEX_MODE, 1, 0, 0, 0, 0, 0},
    '{ROW_QUERY, 0, 0, 65153, 65153, 0, 0, 0},
    '{ROW_QUERY, 0, 0, 64, 64, 0, 0, 0},
    '{ROW_REG, CFG_BOUND_LOW_X, 10, 0, 0, 0, 0, 0},
    '{ROW_REG, CFG_BOUND_HIGH_X, 5, 0, 0, 0, 0, 0},
    '{ROW_QUERY, 0, 0, 0, 0, 1, 0, 0}
  };

  task automatic flag_mismatch(string what);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  function automatic longint nearest_pixel(longint p);
    if (p >= 0) return (p + HALF_UNIT) >>> FRAC_BITS;
    return -(((-p) + HALF_UNIT) >>> FRAC_BITS);
  endfunction

  function automatic bit in_window(longint x, longint y);
    return x >= win_lx && x <= win_hx && y >= win_ly && y <= win_hy;
  endfunction

  function automatic bit [ADDR_W-1:0] store_addr(longint x, longint y);
    return ADDR_W'(y * IMG_WIDTH + x);
  endfunction

  // Round to the nearest pixel and pick the neighbors on the fraction's side
  function automatic lookup_t query_lookup(pos_t px, pos_t py);
    lookup_t g;
    longint  nx, ny, dx, dy, x1, y2;
    g.in_win    = 1'b0;
    g.use_plane = 1'b0;
    g.a0 = '0;
    g.a1 = '0;
    g.a2 = '0;
    g.ax = 0;
    g.ay = 0;
    nx = nearest_pixel(longint'(px));
    ny = nearest_pixel(longint'(py));
    if (!in_window(nx, ny)) return g;
    g.in_win = 1'b1;
    g.a0 = store_addr(nx, ny);
    dx = longint'(px) - nx * PIX_ONE;
    dy = longint'(py) - ny * PIX_ONE;
    if (dx == 0 && dy == 0) return g;
    x1 = (dx >= 0) ? nx + 1 : nx - 1;
    y2 = (dy >= 0) ? ny + 1 : ny - 1;
    if (in_window(x1, ny) && in_window(nx, y2)) begin
      g.use_plane = 1'b1;
      g.a1 = store_addr(x1, ny);
      g.a2 = store_addr(nx, y2);
      g.ax = (dx < 0) ? -dx : dx;
      g.ay = (dy < 0) ? -dy : dy;
    end
    return g;
  endfunction

  function automatic longint plane_value(longint z0, longint z1, longint z2,
                                         longint ax, longint ay);
    longint n;
    n = z0 * PIX_ONE + ax * (z1 - z0) + ay * (z2 - z0);
    if (n < 0) n = 0;
    return n >>> FRAC_BITS;
  endfunction

  function automatic answer_t interpolate_query(pos_t px, pos_t py);
    lookup_t g;
    answer_t a;
    longint  z0, z1, z2, acc;
    g = query_lookup(px, py);
    a.in_win = g.in_win;
    a.pixel  = '0;
    if (!g.in_win) return a;
    z0 = image_copy[g.a0];
    a.pixel = PIX_W'(z0);
    if (!g.use_plane) return a;
    z1 = image_copy[g.a1];
    z2 = image_copy[g.a2];
    if (idx_mode) begin
      a.pixel = PIX_W'(plane_value(z0, z1, z2, g.ax, g.ay));
    end else begin
      // each color channel on its own plane
      acc = 0;
      for (int s = 0; s < PIX_W; s += CHAN_W) begin
        acc |= (plane_value((z0 >> s) & CH_MASK, (z1 >> s) & CH_MASK,
                            (z2 >> s) & CH_MASK, g.ax, g.ay) & CH_MASK) << s;
      end
      a.pixel = PIX_W'(acc);
    end
    return a;
  endfunction

  function automatic bit [PIX_W-1:0] rand_pixel();
    bit [PIX_W-1:0] p;
    p = PIX_W'($urandom);
    case ($urandom_range(0, 4))
      0: p = '0;
      1: p = '1;
      2: begin
        // mix channel extremes
        for (int s = 0; s < PIX_W; s += CHAN_W) begin
          case ($urandom_range(0, 2))
            0: p[s +: CHAN_W] = '0;
            1: p[s +: CHAN_W] = '1;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  function automatic int rand_frac();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return -HALF_UNIT;
      2: return HALF_UNIT - 1;
      3: return $urandom_range(0, 1) ? 1 : -1;
      default: return int'($urandom_range(0, 2 * HALF_UNIT - 1)) - HALF_UNIT;
    endcase
  endfunction

  function automatic int edge_coord(int lo, int hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      2: return lo - 1;
      default: return hi + 1;
    endcase
  endfunction

  // Drive one word at the falling edge, hold until accepted, then predict
  task automatic push_word(in_word_t w, bit typed, answer_t want);
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_ch.action      = w.action;
    in_ch.pos_x       = w.pos_x;
    in_ch.pos_y       = w.pos_y;
    in_ch.write_addr  = w.write_addr;
    in_ch.write_pixel = w.write_pixel;
    in_ch.valid       = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (w.action == ACT_WRITE) begin
      image_copy[w.write_addr]  = w.write_pixel;
      written_map[w.write_addr] = 1'b1;
    end else begin
      pending_answers.push_back(typed ? want : interpolate_query(w.pos_x, w.pos_y));
    end
    @(negedge clk);
  endtask

  task automatic send_write(bit [ADDR_W-1:0] addr, bit [PIX_W-1:0] pixel);
    in_word_t w;
    w.action      = ACT_WRITE;
    w.pos_x       = pos_t'($urandom);
    w.pos_y       = pos_t'($urandom);
    w.write_addr  = addr;
    w.write_pixel = pixel;
    push_word(w, 1'b0, '0);
  endtask

  // Load every entry the query will read before it goes out
  task automatic send_query(pos_t px, pos_t py);
    lookup_t  g;
    in_word_t w;
    g = query_lookup(px, py);
    if (g.in_win && !written_map[g.a0]) send_write(g.a0, rand_pixel());
    if (g.use_plane && !written_map[g.a1]) send_write(g.a1, rand_pixel());
    if (g.use_plane && !written_map[g.a2]) send_write(g.a2, rand_pixel());
    w.action      = ACT_QUERY;
    w.pos_x       = px;
    w.pos_y       = py;
    w.write_addr  = ADDR_W'($urandom);
    w.write_pixel = PIX_W'($urandom);
    push_word(w, 1'b0, '0);
  endtask

  // Drain all results and let trailing writes clear the pipeline
  task automatic settle();
    in_ch.valid = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int value);
    cfg_ch.addr  = idx;
    cfg_ch.data  = CFG_DW'(value);
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      CFG_INDEX_MODE:   idx_mode = value[0];
      CFG_BOUND_LOW_X:  win_lx = value & 'hFF;
      CFG_BOUND_HIGH_X: win_hx = value & 'hFF;
      CFG_BOUND_LOW_Y:  win_ly = value & 'hFF;
      CFG_BOUND_HIGH_Y: win_hy = value & 'hFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Stall the result side in random bursts
  initial begin : result_stall
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) hold--;
      else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct)
        hold = $urandom_range(1, 19);
      out_ch.ready = (hold == 0);
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin : result_check
    answer_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_answers.size() == 0) begin
        flag_mismatch("result word with no query pending");
      end else begin
        want = pending_answers.pop_front();
        if (out_ch.inside_res !== want.in_win)
          flag_mismatch($sformatf("inside_res %0b, expected %0b",
                                  out_ch.inside_res, want.in_win));
        if (out_ch.pixel_out !== want.pixel)
          flag_mismatch($sformatf("pixel_out %06h, expected %06h",
                                  out_ch.pixel_out, want.pixel));
      end
    end
  end

  initial begin : watchdog
    #3000000;
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    drow_t    r;
    in_word_t w;
    int       tx, ty, cx, cy, pick;
    int       mode, lx, hx, ly, hy;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_WRITE;
    in_ch.pos_x        = '0;
    in_ch.pos_y        = '0;
    in_ch.write_addr   = '0;
    in_ch.write_pixel  = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.addr        = CFG_INDEX_MODE;
    cfg_ch.data        = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      case (r.kind)
        ROW_WRITE: send_write(ADDR_W'(r.a), PIX_W'(r.b));
        ROW_REG: begin
          settle();
          write_reg(cfg_idx_t'(r.a), r.b);
        end
        default: begin
          w.action      = ACT_QUERY;
          w.pos_x       = pos_t'(r.px);
          w.pos_y       = pos_t'(r.py);
          w.write_addr  = ADDR_W'($urandom);
          w.write_pixel = PIX_W'($urandom);
          push_word(w, r.typed, answer_t'{r.want_inside, PIX_W'(r.want_pixel)});
        end
      endcase
    end

    // Random phases, each under its own register setting
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      mode = ph % 2;
      lx = 0;
      hx = 255;
      ly = 0;
      hy = 255;
      case (ph)
        0, 1: ;
        4: begin
          lx = $urandom_range(0, 255);
          hx = lx;
          ly = $urandom_range(0, 255);
          hy = ly;
        end
        5: begin
          lx = $urandom_range(1, 255);
          hx = $urandom_range(0, lx - 1);
          ly = $urandom_range(0, 200);
          hy = ly + $urandom_range(0, 55);
        end
        6: begin
          lx = $urandom_range(200, 255);
          hy = $urandom_range(0, 40);
        end
        7: begin
          ly = $urandom_range(1, 255);
          hy = $urandom_range(0, ly - 1);
          lx = $urandom_range(0, 128);
          hx = lx + $urandom_range(0, 127);
        end
        N_PHASES - 1: mode = $urandom_range(0, 1);
        default: begin
          lx = $urandom_range(0, 250);
          hx = (lx + 40 > 255) ? 255 : lx + $urandom_range(2, 40);
          ly = $urandom_range(0, 250);
          hy = (ly + 40 > 255) ? 255 : ly + $urandom_range(2, 40);
        end
      endcase
      write_reg(CFG_INDEX_MODE, mode);
      write_reg(CFG_BOUND_LOW_X, lx);
      write_reg(CFG_BOUND_HIGH_X, hx);
      write_reg(CFG_BOUND_LOW_Y, ly);
      write_reg(CFG_BOUND_HIGH_Y, hy);

      // pacing for this phase; the last one runs flat out
      if (ph == N_PHASES - 1) begin
        send_gap_pct   = 0;
        sink_stall_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: send_gap_pct = 0;
          1: send_gap_pct = 5;
          2: send_gap_pct = 25;
          default: send_gap_pct = 60;
        endcase
        case ($urandom_range(0, 3))
          0: sink_stall_pct = 0;
          1: sink_stall_pct = 5;
          2: sink_stall_pct = 25;
          default: sink_stall_pct = 60;
        endcase
      end

      // working tile, so written pixels get read again
      tx = (lx <= hx) ? $urandom_range(lx, hx) : $urandom_range(0, 255);
      ty = (ly <= hy) ? $urandom_range(ly, hy) : $urandom_range(0, 255);

      for (int n = 0; n < PHASE_LEN; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          cx = tx + $urandom_range(0, 5) - 1;
          cy = ty + $urandom_range(0, 5) - 1;
          send_query(pos_t'(cx * PIX_ONE + rand_frac()), pos_t'(cy * PIX_ONE + rand_frac()));
        end else if (pick < 70) begin
          if ($urandom_range(0, 1))
            send_write(ADDR_W'($urandom), rand_pixel());
          else
            send_write(store_addr((tx + $urandom_range(0, 5)) & 255,
                                  (ty + $urandom_range(0, 5)) & 255), rand_pixel());
        end else if (pick < 80) begin
          cx = edge_coord(lx, hx);
          cy = edge_coord(ly, hy);
          send_query(pos_t'(cx * PIX_ONE + rand_frac()), pos_t'(cy * PIX_ONE + rand_frac()));
        end else if (pick < 90) begin
          send_query(pos_t'($urandom), pos_t'($urandom));
        end else begin
          cx = (lx <= hx) ? $urandom_range(lx, hx) : $urandom_range(0, 255);
          cy = (ly <= hy) ? $urandom_range(ly, hy) : $urandom_range(0, 255);
          send_query(pos_t'(cx * PIX_ONE), pos_t'(cy * PIX_ONE + rand_frac()));
        end
      end
    end

    // Drain and let the pipeline run dry
    in_ch.valid = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: planar_pixel_interpolator_core.f
+incdir+sv
sv/ppi_pkg.sv
sv/ppi_if.sv
sv/ppi_bank_ram.sv
sv/ppi_round.sv
sv/ppi_store.sv
sv/ppi_plane.sv
sv/planar_pixel_interpolator_core.sv
test/tb.sv
